FILE: src/bpa_pkg.sv
package bpa_pkg;

    localparam int FRAME_COUNT_DEF = 4096;
    localparam int TOP_ORDER_DEF   = 10;
    localparam int MAP_WORD_W      = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOMEM = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    typedef struct packed {
        logic        command;
        logic [11:0] frame;
        logic [3:0]  block_order;
    } bpa_req_t;

    typedef struct packed {
        logic [11:0] result_frame;
        logic [1:0]  status;
        logic [3:0]  merged_order;
    } bpa_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RAMP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_A_RD,
        ST_A_WR,
        ST_F_CLR_RD,
        ST_F_CLR_WR,
        ST_F_BUD_RD,
        ST_F_BUD_CHK,
        ST_F_SET_RD,
        ST_F_SET_WR,
        ST_DONE
    } bpa_state_t;

endpackage

FILE: src/buddy_page_allocator_unit.sv
// Channel  Ports         Payload    Direction
// request  s_valid/ready bpa_req_t  in   (command, frame, block_order)
// result   m_valid/ready bpa_rsp_t  out  (result_frame, status, merged_order)
//
// One request at a time: after acceptance, ST_RAMP builds the order's map base. Allocate scans
// one 32-bit map word per ST_SCAN_RD/CHK pair upward from its order, then per level runs
// ST_A_RD/WR, clearing the block and marking each split half free. Free runs ST_F_CLR_RD/WR and
// ST_F_BUD_RD/CHK per merge level and ST_F_SET_RD/WR to mark the final block; ST_DONE moves the
// result out. Reset clears all 2*FRAME_COUNT/32 map words (256 by default). A result waits in
// the output register while the next request runs; only the next result stalls behind it.
module buddy_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int TOP_ORDER   = TOP_ORDER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bpa_pkg::bpa_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bpa_pkg::bpa_rsp_t  m_data
);

    localparam int WW    = MAP_WORD_W;
    localparam int WORDS = (2 * FRAME_COUNT + WW - 1) / WW;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(2 * FRAME_COUNT) + 6;
    localparam int FW    = $clog2(FRAME_COUNT) + 1;
    localparam int FW2   = (FW > 12) ? FW : 12;
    localparam int FXW   = ((FW2 > TOP_ORDER + 1) ? FW2 : TOP_ORDER + 1) + 1;
    localparam int KW    = $clog2(TOP_ORDER + 1);

    bpa_state_t state_reg, state_next;
    logic           cmd_reg,   cmd_next;
    logic [KW-1:0]  tk_reg,    tk_next;
    logic [KW-1:0]  k_reg,     k_next;
    logic [BW-1:0]  base_reg,  base_next;
    logic [FXW-1:0] f_reg,     f_next;
    logic [FXW-1:0] res_reg,   res_next;
    logic           val_reg,   val_next;
    logic [1:0]     st_reg,    st_next;
    logic [3:0]     mo_reg,    mo_next;
    logic [AW-1:0]  waddr_reg, waddr_next;
    logic           m_valid_reg, m_valid_next;
    bpa_rsp_t       rsp_reg, rsp_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [WW-1:0]  ram_wdata, ram_rdata;

    logic [FXW-1:0] one_k, one_ord, tgt, bud, frame_x;
    logic [BW-1:0]  step, bidx, lastbit, nbase, gidx;
    logic [AW-1:0]  bword;
    logic [4:0]     bpos, lpos;
    logic [WW-1:0]  lo_mask, hi_mask, hit;
    logic           bud_fits, out_free, empty, last_word;
    logic [FXW:0]   bud_end, req_end;

    bpa_map_ram #(.WORDS(WORDS), .AW(AW), .DW(WW)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        one_k   = FXW'(1) << k_reg;
        one_ord = FXW'(1) << s_data.block_order;
        frame_x = FXW'(s_data.frame);
        req_end = {1'b0, frame_x} + {1'b0, one_ord};
        bud     = f_reg ^ one_k;
        bud_end = {1'b0, bud} + {1'b0, one_k};
        bud_fits = bud_end <= (FXW + 1)'(FRAME_COUNT);
        tgt     = (state_reg == ST_F_BUD_RD || state_reg == ST_F_BUD_CHK) ? bud : f_reg;
        step    = BW'(FRAME_COUNT) >> k_reg;
        nbase   = base_reg + step;
        bidx    = base_reg + BW'(tgt >> k_reg);
        bword   = bidx[AW+4:5];
        bpos    = bidx[4:0];
        empty   = (step == '0);
        lastbit = nbase - BW'(1);
        lo_mask = (waddr_reg == base_reg[AW+4:5]) ? ({WW{1'b1}} << base_reg[4:0])
                                                  : {WW{1'b1}};
        hi_mask = (waddr_reg == lastbit[AW+4:5]) ? ({WW{1'b1}} >> (5'd31 - lastbit[4:0]))
                                                 : {WW{1'b1}};
        hit       = empty ? '0 : (ram_rdata & lo_mask & hi_mask);
        last_word = empty || (waddr_reg == lastbit[AW+4:5]);
        lpos = 5'd0;
        for (int j = WW - 1; j >= 0; j--) begin
            if (hit[j]) begin
                lpos = 5'(j);
            end
        end
        gidx     = BW'({waddr_reg, lpos}) - base_reg;
        out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            waddr_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            waddr_reg   <= waddr_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg  <= cmd_next;
        tk_reg   <= tk_next;
        k_reg    <= k_next;
        base_reg <= base_next;
        f_reg    <= f_next;
        res_reg  <= res_next;
        val_reg  <= val_next;
        st_reg   <= st_next;
        mo_reg   <= mo_next;
        rsp_reg  <= rsp_next;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        tk_next      = tk_reg;
        k_next       = k_reg;
        base_next    = base_reg;
        f_next       = f_reg;
        res_next     = res_reg;
        val_next     = val_reg;
        st_next      = st_reg;
        mo_next      = mo_reg;
        waddr_next   = waddr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rsp_next     = rsp_reg;
        ram_we       = 1'b0;
        ram_waddr    = bword;
        ram_wdata    = ram_rdata;
        ram_raddr    = bword;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = waddr_reg;
                ram_wdata  = '0;
                waddr_next = waddr_reg + AW'(1);
                if (waddr_reg == AW'(WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next  = s_data.command;
                    tk_next   = KW'(s_data.block_order);
                    k_next    = '0;
                    base_next = '0;
                    f_next    = frame_x;
                    res_next  = '0;
                    st_next   = STATUS_OK;
                    mo_next   = s_data.block_order;
                    if (32'(s_data.block_order) > 32'(TOP_ORDER)) begin
                        st_next    = STATUS_BAD;
                        state_next = ST_DONE;
                    end else if (s_data.command == CMD_FREE &&
                                 (((frame_x & (one_ord - FXW'(1))) != '0) ||
                                  (req_end > (FXW + 1)'(FRAME_COUNT)))) begin
                        st_next    = STATUS_BAD;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RAMP;
                    end
                end
            end
            ST_RAMP: begin
                if (k_reg == tk_reg) begin
                    waddr_next = base_reg[AW+4:5];
                    if (cmd_reg == CMD_ALLOC) begin
                        state_next = ST_SCAN_RD;
                    end else if (32'(k_reg) < 32'(TOP_ORDER)) begin
                        state_next = ST_F_CLR_RD;
                    end else begin
                        state_next = ST_F_SET_RD;
                    end
                end else begin
                    base_next = nbase;
                    k_next    = k_reg + KW'(1);
                end
            end
            ST_SCAN_RD: begin
                ram_raddr  = waddr_reg;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (hit != '0) begin
                    f_next     = FXW'(gidx) << k_reg;
                    res_next   = FXW'(gidx) << k_reg;
                    val_next   = 1'b0;
                    state_next = ST_A_RD;
                end else if (last_word) begin
                    if (32'(k_reg) == 32'(TOP_ORDER)) begin
                        st_next    = STATUS_NOMEM;
                        res_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        base_next  = nbase;
                        k_next     = k_reg + KW'(1);
                        waddr_next = nbase[AW+4:5];
                        state_next = ST_SCAN_RD;
                    end
                end else begin
                    waddr_next = waddr_reg + AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_A_RD: begin
                state_next = ST_A_WR;
            end
            ST_A_WR: begin
                ram_we          = 1'b1;
                ram_wdata[bpos] = val_reg;
                if (k_reg > tk_reg) begin
                    // Step down one order and mark the upper half as free.
                    k_next     = k_reg - KW'(1);
                    base_next  = base_reg - (BW'(FRAME_COUNT) >> (k_reg - KW'(1)));
                    f_next     = res_reg | (FXW'(1) << (k_reg - KW'(1)));
                    val_next   = 1'b1;
                    state_next = ST_A_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_F_CLR_RD: begin
                state_next = ST_F_CLR_WR;
            end
            ST_F_CLR_WR: begin
                ram_we          = 1'b1;
                ram_wdata[bpos] = 1'b0;
                state_next      = ST_F_BUD_RD;
            end
            ST_F_BUD_RD: begin
                state_next = bud_fits ? ST_F_BUD_CHK : ST_F_SET_RD;
            end
            ST_F_BUD_CHK: begin
                if (!ram_rdata[bpos]) begin
                    state_next = ST_F_SET_RD;
                end else begin
                    ram_we          = 1'b1;
                    ram_wdata[bpos] = 1'b0;
                    f_next          = f_reg & ~one_k;
                    base_next       = nbase;
                    k_next          = k_reg + KW'(1);
                    if (32'(k_reg) + 1 < TOP_ORDER) begin
                        state_next = ST_F_CLR_RD;
                    end else begin
                        state_next = ST_F_SET_RD;
                    end
                end
            end
            ST_F_SET_RD: begin
                state_next = ST_F_SET_WR;
            end
            ST_F_SET_WR: begin
                ram_we          = 1'b1;
                ram_wdata[bpos] = 1'b1;
                res_next        = f_reg;
                mo_next         = 4'(k_reg);
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    rsp_next.result_frame = 12'(res_reg);
                    rsp_next.status       = st_reg;
                    rsp_next.merged_order = mo_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

FILE: src/bpa_map_ram.sv
module bpa_map_ram #(
    parameter int WORDS = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [WORDS];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: bench/buddy_page_allocator_unit_tb.sv
module buddy_page_allocator_unit_tb;
    import bpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES      = FRAME_COUNT_DEF;
    localparam int TOP         = TOP_ORDER_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 1000;

    typedef struct packed {
        logic [11:0] frame;
        logic [3:0]  order;
    } block_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bpa_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bpa_rsp_t m_data;

    bit       free_heads [0:2*FRAMES-1];
    bpa_rsp_t pending_rsp [$];
    block_t   held_blocks [$];
    int       sender_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       fail_count = 0;
    int       cycle_count = 0;

    buddy_page_allocator_unit i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[buddy_page_allocator_unit] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        bpa_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result %h", m_data);
                fail_count++;
            end else begin
                want = pending_rsp[0];
                pending_rsp.delete(0);
                if (m_data.result_frame !== want.result_frame) begin
                    $error("result_frame expected %0d actual %0d",
                           want.result_frame, m_data.result_frame);
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.merged_order !== want.merged_order) begin
                    $error("merged_order expected %0d actual %0d",
                           want.merged_order, m_data.merged_order);
                    fail_count++;
                end
            end
        end
    end

    function automatic int head_index(int f, int k);
        int base;
        base = 0;
        for (int j = 0; j < k; j++) base += FRAMES >> j;
        return base + (f >> k);
    endfunction

    function automatic bit fits(int f, int k);
        return f + (1 << k) <= FRAMES;
    endfunction

    function automatic bit head_get(int f, int k);
        if (!fits(f, k)) return 1'b0;
        return free_heads[head_index(f, k)];
    endfunction

    function automatic void head_put(int f, int k, bit v);
        if (fits(f, k)) free_heads[head_index(f, k)] = v;
    endfunction

    function automatic bpa_rsp_t predict_alloc_free(bpa_req_t req);
        bpa_rsp_t rsp;
        int       order;
        int       f;
        int       k;
        bit       found;
        order = req.block_order;
        rsp.result_frame = '0;
        rsp.status = STATUS_OK;
        rsp.merged_order = req.block_order;
        found = 1'b0;
        f = 0;
        if (order > TOP) begin
            rsp.status = STATUS_BAD;
        end else if (req.command == CMD_ALLOC) begin
            for (k = order; k <= TOP; k++) begin
                for (int idx = 0; idx < (FRAMES >> k); idx++) begin
                    if (free_heads[head_index(0, k) + idx]) begin
                        found = 1'b1;
                        f = idx << k;
                        break;
                    end
                end
                if (found) break;
            end
            if (!found) begin
                rsp.status = STATUS_NOMEM;
            end else begin
                head_put(f, k, 1'b0);
                while (k > order) begin
                    k--;
                    head_put(f | (1 << k), k, 1'b1);
                end
                rsp.result_frame = f[11:0];
            end
        end else begin
            f = req.frame;
            if ((f & ((1 << order) - 1)) != 0 || !fits(f, order)) begin
                rsp.status = STATUS_BAD;
            end else begin
                k = order;
                while (k < TOP) begin
                    head_put(f, k, 1'b0);
                    if (!head_get(f ^ (1 << k), k)) break;
                    head_put(f ^ (1 << k), k, 1'b0);
                    f &= ~(1 << k);
                    k++;
                end
                head_put(f, k, 1'b1);
                rsp.result_frame = f[11:0];
                rsp.merged_order = k[3:0];
            end
        end
        return rsp;
    endfunction

    task automatic send_request(logic cmd, int frame, int order);
        bpa_req_t req;
        bpa_rsp_t rsp;
        block_t   blk;
        req.command = cmd;
        req.frame = frame[11:0];
        req.block_order = order[3:0];
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rsp = predict_alloc_free(req);
        pending_rsp.push_back(rsp);
        if (cmd == CMD_ALLOC && rsp.status == STATUS_OK) begin
            blk.frame = rsp.result_frame;
            blk.order = order[3:0];
            held_blocks.push_back(blk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rsp.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 0, 11);
        send_request(CMD_FREE, 0, 15);
        send_request(CMD_FREE, 1, 1);
        send_request(CMD_FREE, 4095, 0);
        send_request(CMD_FREE, 3072, 10);
        send_request(CMD_FREE, 4094, 1);
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_FREE, 0, 10);
        send_request(CMD_ALLOC, 4095, 0);
        send_request(CMD_ALLOC, 0, 10);
        send_request(CMD_FREE, 0, 10);
        send_request(CMD_FREE, 0, 10);
        send_request(CMD_FREE, 1024, 10);
        send_request(CMD_FREE, 2048, 10);
        send_request(CMD_ALLOC, 0, 3);
        send_request(CMD_FREE, 0, 3);
        send_request(CMD_FREE, 4095, 12);
        send_request(CMD_ALLOC, 0, 10);
        send_request(CMD_ALLOC, 0, 10);
        // Overlapping free of a smaller order inside the order-10 block at 2048, which is already free.
        send_request(CMD_FREE, 2048, 5);
        drain_results();
        held_blocks.delete();
    endtask

    task automatic test_random(int items, int idle_pct, int stall_pct);
        int     pick;
        int     roll;
        block_t blk;
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                send_request(CMD_ALLOC, $urandom_range(4095), $urandom_range(TOP));
            end else if (roll < 90 && held_blocks.size() != 0) begin
                pick = $urandom_range(held_blocks.size() - 1);
                blk = held_blocks[pick];
                held_blocks.delete(pick);
                send_request(CMD_FREE, int'(blk.frame), int'(blk.order));
            end else if (roll < 93) begin
                send_request(CMD_FREE, $urandom_range(3) * 1024, TOP);
            end else begin
                send_request(1'($urandom_range(1)), $urandom_range(4095),
                             $urandom_range(15));
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(300, 0, 0);
        test_random(280, 87, 0);
        test_random(280, 0, 87);
        test_random(290, 12, 12);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && pending_rsp.size() == 0) begin
            $display("[buddy_page_allocator_unit] OK");
        end else begin
            $display("[buddy_page_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule
